/* rtl/core/ptir_pkg.sv */
// ----------------------------------------------------------------------------
// ptir_pkg
// Shared types, codes and field widths for the pair table core.
// ----------------------------------------------------------------------------
package ptir_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEPTH_DEF       = 16;
    localparam int KEY_WIDTH_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int MODE_W        = 2;
    localparam int KEY_FIELD_W   = 16;
    localparam int VALUE_FIELD_W = 16;
    localparam int INDEX_W       = 4;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_BITS = KEY_FIELD_W + VALUE_FIELD_W + INDEX_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = KEY_FIELD_W + VALUE_FIELD_W + COUNT_FIELD_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

/* rtl/core/ptir_pair_ram.sv */
// ----------------------------------------------------------------------------
// ptir_pair_ram
// Simple dual-port table memory: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module ptir_pair_ram #(
    parameter int DEPTH = ptir_pkg::DEPTH_DEF,
    parameter int WIDTH = ptir_pkg::KEY_WIDTH_DEF + ptir_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read at an address written in the same cycle returns the old entry.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/pair_table_insert_remove_core.sv */
// Steps: each item passes S_IDLE and S_DISPATCH; an add with duplicates allowed, a bad
// index or an ignored mode then goes to S_DONE, a read passes S_FETCH, an add with the
// duplicate check walks S_SCAN up to the count (less on an early match) and a remove
// passes S_FETCH and S_SHIFT over the entries above the index, all ending in S_DONE.
// Throughput: one item at a time; the next is accepted the cycle after its result
// enters the output register. Reset: synchronous, active low; clears the count and sets allow_duplicates to 1.
// ----------------------------------------------------------------------------
// pair_table_insert_remove_core
// Packed table of key/value pairs in insertion order with add, remove and read
// operations, an optional duplicate check and a running entry count.
// ----------------------------------------------------------------------------
module pair_table_insert_remove_core #(
    parameter int DEPTH       = ptir_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = ptir_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = ptir_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input items.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // s_axis_tdata: key [15:0], value [31:16], index [35:32], zero fill above.
    input  logic [ptir_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: mode [1:0].
    input  logic [ptir_pkg::MODE_W-1:0]    s_axis_tuser,
    // Result items.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // m_axis_tdata: key_out [15:0], value_out [31:16], entry_count [36:32],
    // zero fill above.
    output logic [ptir_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: status [1:0].
    output logic [ptir_pkg::STATUS_W-1:0]  m_axis_tuser,
    // Configuration: allow_duplicates.
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata
);

    import ptir_pkg::*;

    // Address and count widths follow from the table size, the entry width from the key and value widths.
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int DW   = KEY_WIDTH + VALUE_WIDTH;
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FETCH,
        S_SHIFT,
        S_DONE
    } t_state;

    // Control state.
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_allow_dup, n_allow_dup;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_dst, n_dst;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;

    // Item and result payload.
    t_mode                    r_mode, n_mode;
    logic [KEY_WIDTH-1:0]     r_key, n_key;
    logic [VALUE_WIDTH-1:0]   r_val, n_val;
    logic [INDEX_W-1:0]       r_idx, n_idx;
    t_status                  r_res_status, n_res_status;
    logic [KEY_FIELD_W-1:0]   r_res_key, n_res_key;
    logic [VALUE_FIELD_W-1:0] r_res_val, n_res_val;
    t_status                  r_out_status, n_out_status;
    logic [KEY_FIELD_W-1:0]   r_out_key, n_out_key;
    logic [VALUE_FIELD_W-1:0] r_out_val, n_out_val;
    logic [COUNT_FIELD_W-1:0] r_out_count, n_out_count;

    // Memory ports.
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [DW-1:0] w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [DW-1:0] w_rd_data;

    logic                   w_issue;
    logic                   w_match;
    logic                   w_append;
    logic [KEY_WIDTH-1:0]   w_rd_key;
    logic [VALUE_WIDTH-1:0] w_rd_val;

    assign w_rd_key = w_rd_data[DW-1:VALUE_WIDTH];
    assign w_rd_val = w_rd_data[VALUE_WIDTH-1:0];

    // Both scan and shift walk a read pointer up to the count; a read issued in
    // one cycle delivers its entry in the next, marked by r_pend.
    assign w_issue = (r_ptr < r_count);
    assign w_match = (w_rd_data == {r_key, r_val});

    ptir_pair_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DW)
    ) u_ptir_pair_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_allow_dup  = r_allow_dup;
        n_ptr        = r_ptr;
        n_dst        = r_dst;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_mode       = r_mode;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_key    = r_res_key;
        n_res_val    = r_res_val;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_val    = r_out_val;
        n_out_count  = r_out_count;

        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = {r_key, r_val};
        w_rd_addr = r_ptr[AW-1:0];
        w_append  = 1'b0;

        if (i_cfg_we) begin
            n_allow_dup = i_cfg_wdata;
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = t_mode'(s_axis_tuser);
                    n_key   = KEY_WIDTH'(s_axis_tdata[KEY_FIELD_W-1:0]);
                    n_val   = VALUE_WIDTH'(
                        s_axis_tdata[KEY_FIELD_W +: VALUE_FIELD_W]);
                    n_idx   = s_axis_tdata[KEY_FIELD_W + VALUE_FIELD_W +: INDEX_W];
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                // The entry at the index is read now in case it is needed.
                w_rd_addr = AW'(r_idx);
                case (r_mode)
                    MODE_ADD: begin
                        if (!r_allow_dup) begin
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end else begin
                            w_append = 1'b1;
                        end
                    end
                    MODE_REMOVE, MODE_READ: begin
                        if (CMPW'(r_idx) >= CMPW'(r_count)) begin
                            n_res_status = ST_RANGE;
                            n_res_key    = '0;
                            n_res_val    = '0;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                        n_res_key    = '0;
                        n_res_val    = '0;
                        n_state      = S_DONE;
                    end
                endcase
            end

            S_FETCH: begin
                n_res_status = ST_OK;
                n_res_key    = KEY_FIELD_W'(w_rd_key);
                n_res_val    = VALUE_FIELD_W'(w_rd_val);
                if (r_mode == MODE_REMOVE) begin
                    n_ptr   = CW'(r_idx) + CW'(1);
                    n_dst   = AW'(r_idx);
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_SCAN: begin
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                n_pend = w_issue;
                if (r_pend && w_match) begin
                    n_res_status = ST_DUP;
                    n_res_key    = '0;
                    n_res_val    = '0;
                    n_state      = S_DONE;
                end else if (!w_issue) begin
                    w_append = 1'b1;
                end
            end

            S_SHIFT: begin
                // Read one entry ahead and write it one place lower.
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                n_pend = w_issue;
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_dst;
                    w_wr_data = w_rd_data;
                    n_dst     = r_dst + AW'(1);
                end
                if (!w_issue) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_key    = r_res_key;
                    n_out_val    = r_res_val;
                    n_out_count  = COUNT_FIELD_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append after the duplicate check, or directly when duplicates pass.
        if (w_append) begin
            n_res_key = '0;
            n_res_val = '0;
            if (r_count == CW'(DEPTH)) begin
                n_res_status = ST_FULL;
            end else begin
                w_wr_en      = 1'b1;
                n_count      = r_count + CW'(1);
                n_res_status = ST_OK;
            end
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_dst        <= n_dst;
        r_res_status <= n_res_status;
        r_res_key    <= n_res_key;
        r_res_val    <= n_res_val;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_val    <= n_out_val;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_allow_dup <= 1'b1;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_allow_dup <= n_allow_dup;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(M_TDATA_W - M_TDATA_BITS)'(0), r_out_count, r_out_val, r_out_key};

endmodule

/* rtl/core/ptir_checker.sv */
// ----------------------------------------------------------------------------
// ptir_checker
// Port-level checks on the result stream of the pair table core.
// ----------------------------------------------------------------------------
module ptir_checker #(
    parameter int DEPTH = ptir_pkg::DEPTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ptir_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [ptir_pkg::STATUS_W-1:0]  m_axis_tuser
);

    import ptir_pkg::*;

    localparam int CNT_LO = KEY_FIELD_W + VALUE_FIELD_W;

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Rejected operations carry no pair.
    a_err_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_DUP || m_axis_tuser == ST_FULL ||
            m_axis_tuser == ST_RANGE) |->
            m_axis_tdata[CNT_LO-1:0] == '0)
        else $error("rejected result carries a nonzero pair");

    // A full rejection reports a full table.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |->
            m_axis_tdata[CNT_LO +: COUNT_FIELD_W] == COUNT_FIELD_W'(DEPTH))
        else $error("table full reported with a count below the depth");

endmodule

bind pair_table_insert_remove_core ptir_checker #(
    .DEPTH (DEPTH)
) u_ptir_checker (.*);

/* bench/pair_table_insert_remove_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_table_insert_remove_core_tb
// Self-checking bench for the pair table core. A short directed table covers
// the empty, full and out-of-range cases and the duplicate check in both
// settings. Random add, remove and read traffic then follows, with random
// gaps on both streams. Every result is compared against a model of the
// table that the bench keeps for itself.
// ----------------------------------------------------------------------------
module pair_table_insert_remove_core_tb;

    import ptir_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    // The mode field has one code with no operation behind it. The block
    // must answer it with an ok status and leave the table alone.
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    // The settle wait is sized from the table depth. It is spent before a
    // register write and at the end of the run.
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 230;

    // One result item as the block reports it.
    typedef struct packed {
        t_status          status;
        logic [15:0]      key_out;
        logic [15:0]      value_out;
        logic [4:0]       entry_count;
    } table_result_t;

    // One row of the directed table. A row either writes the register or
    // sends an item. An item row may repeat, and then the key and the value
    // advance by one on each repeat. When typed is set, the result is given
    // in the row. Otherwise it comes from the table model.
    typedef struct packed {
        logic             is_cfg;
        logic             cfg_val;
        logic [MODE_W-1:0] mode;
        logic [15:0]      key;
        logic [15:0]      value;
        logic [3:0]       index;
        logic [7:0]       reps;
        logic             typed;
        table_result_t    want;
    } pair_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata;
    logic [MODE_W-1:0]       s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    i_cfg_we;
    logic                    i_cfg_wdata;

    // The bench's own copy of the table and of the register.
    logic [15:0]     pair_keys [DEPTH];
    logic [15:0]     pair_vals [DEPTH];
    int              pair_count;
    bit              allow_dup;

    // Results that accepted items still owe, oldest first.
    table_result_t   pending_results [$];
    pair_row_t       directed_ops [$];

    int  fails;
    int  cycles;
    int  rx_wait;
    bit  tx_calm;
    bit  rx_calm;
    int  n_add, n_remove, n_read, n_ignored;
    int  n_dup, n_full, n_range, n_checked;

    pair_table_insert_remove_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // This counter stops a run that has hung.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results still owed", cycles,
                   pending_results.size());
            $display("[pair_table_insert_remove_core] ERROR");
            $finish;
        end
    end

    // Applies one item to the model table and returns the result it owes.
    // An add checks for an identical pair first, and only when duplicates
    // are barred. Only then does it check for a full table. A remove closes
    // the gap by moving every later entry down by one place.
    function automatic table_result_t table_apply(logic [MODE_W-1:0] mode,
                                                  logic [15:0] key,
                                                  logic [15:0] value,
                                                  logic [3:0] index);
        table_result_t r;
        bit            dup;
        int            i;
        r = '0;
        r.status = ST_OK;
        case (mode)
            MODE_ADD: begin
                dup = 1'b0;
                if (!allow_dup) begin
                    for (i = 0; i < pair_count; i++) begin
                        if (pair_keys[i] == key && pair_vals[i] == value) dup = 1'b1;
                    end
                end
                if (dup) begin
                    r.status = ST_DUP;
                end else if (pair_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pair_keys[pair_count] = key;
                    pair_vals[pair_count] = value;
                    pair_count++;
                end
            end
            MODE_REMOVE, MODE_READ: begin
                if (int'(index) >= pair_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.key_out   = pair_keys[index];
                    r.value_out = pair_vals[index];
                    if (mode == MODE_REMOVE) begin
                        for (i = int'(index); i + 1 < pair_count; i++) begin
                            pair_keys[i] = pair_keys[i + 1];
                            pair_vals[i] = pair_vals[i + 1];
                        end
                        pair_count--;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = pair_count[4:0];
        return r;
    endfunction

    // A random 16-bit field that lands on either extreme now and then.
    function automatic logic [15:0] rand_word();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic pair_row_t op_typed(logic [MODE_W-1:0] mode, logic [15:0] key,
                                           logic [15:0] value, logic [3:0] index,
                                           t_status st, logic [15:0] k_out,
                                           logic [15:0] v_out, logic [4:0] cnt);
        pair_row_t row;
        row = '0;
        row.mode  = mode;
        row.key   = key;
        row.value = value;
        row.index = index;
        row.reps  = 8'd1;
        row.typed = 1'b1;
        row.want  = '{st, k_out, v_out, cnt};
        return row;
    endfunction

    function automatic pair_row_t op_model(logic [MODE_W-1:0] mode, logic [15:0] key,
                                           logic [15:0] value, logic [3:0] index,
                                           logic [7:0] reps);
        pair_row_t row;
        row = '0;
        row.mode  = mode;
        row.key   = key;
        row.value = value;
        row.index = index;
        row.reps  = reps;
        return row;
    endfunction

    function automatic pair_row_t cfg_row(logic allow);
        pair_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = allow;
        return row;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(pair_row_t row);
        directed_ops = {directed_ops, row};
    endfunction

    // Sends one item and waits until the block takes it. tvalid stays high
    // after the item is taken. The next call either puts new data on the bus
    // in the same time step or lowers tvalid for its gap. A caller that lets
    // time pass between two calls lowers tvalid first.
    task automatic put_op(logic [MODE_W-1:0] mode, logic [15:0] key, logic [15:0] value,
                          logic [3:0] index, bit typed, table_result_t want);
        int            gap;
        table_result_t r;
        table_result_t owed;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - S_TDATA_BITS){1'b0}}, index, value, key};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        // The block takes the item at this edge, so the model moves with it.
        r = table_apply(mode, key, value, index);
        owed = typed ? want : r;
        pending_results = {pending_results, owed};
        case (mode)
            MODE_ADD:    n_add++;
            MODE_REMOVE: n_remove++;
            MODE_READ:   n_read++;
            default:     n_ignored++;
        endcase
        case (r.status)
            ST_DUP:   n_dup++;
            ST_FULL:  n_full++;
            ST_RANGE: n_range++;
            default: ;
        endcase
    endtask

    // Holds the sender back until every result owed has come. tvalid goes
    // low first, and the block sees it low before the next item.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // The register is written only while the block is idle.
    task automatic write_allow(logic allow);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= allow;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        allow_dup = allow;
    endtask

    // Random traffic. While the table fills, adds are more common. Once the
    // table is full, the mix turns toward removes until the table runs
    // empty, so both ends of the count are reached again and again. Many
    // adds copy a stored pair, or half of one, to exercise the duplicate
    // check. Most indexes fall inside the table, and a few fall beyond it.
    task automatic run_phase(int quota);
        int                done;
        int                iter;
        int                r;
        int                pick;
        bit                draining;
        logic [MODE_W-1:0] mode;
        logic [15:0]       key;
        logic [15:0]       value;
        logic [3:0]        index;
        done = 0;
        iter = 0;
        draining = 1'b0;
        while (done < quota) begin
            if (iter % 64 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            iter++;
            if (pair_count == DEPTH && $urandom_range(0, 5) == 0) draining = 1'b1;
            else if (pair_count == 0 && $urandom_range(0, 2) == 0) draining = 1'b0;
            r     = $urandom_range(0, 99);
            key   = rand_word();
            value = rand_word();
            index = 4'($urandom_range(0, 15));
            if (r < 3) mode = MODE_IGNORED;
            else if (r < (draining ? 25 : 65)) mode = MODE_ADD;
            else if (r < (draining ? 72 : 82)) mode = MODE_REMOVE;
            else mode = MODE_READ;
            if (mode == MODE_ADD && pair_count > 0) begin
                pick = $urandom_range(0, pair_count - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        key   = pair_keys[pick];
                        value = pair_vals[pick];
                    end
                    3: key = pair_keys[pick];
                    4: value = pair_vals[pick];
                    default: ;
                endcase
            end else if (mode != MODE_ADD && pair_count > 0 && $urandom_range(0, 7) != 0) begin
                index = 4'($urandom_range(0, pair_count - 1));
            end
            if ($urandom_range(0, 119) == 0) drain_results();
            put_op(mode, key, value, index, 1'b0, '0);
            if (mode != MODE_IGNORED) done++;
        end
    endtask

    // Result side. Every result is compared with the oldest one owed. The
    // receiver stalls for a random number of cycles after each result.
    task automatic check_result();
        table_result_t want;
        if (pending_results.size() == 0) begin
            $error("result with nothing owed: status %0d key %h value %h count %0d",
                   m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[36:32]);
            fails++;
        end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (m_axis_tuser != want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                fails++;
            end
            if (m_axis_tdata[15:0] != want.key_out) begin
                $error("key_out: expected %h, got %h", want.key_out, m_axis_tdata[15:0]);
                fails++;
            end
            if (m_axis_tdata[31:16] != want.value_out) begin
                $error("value_out: expected %h, got %h", want.value_out,
                       m_axis_tdata[31:16]);
                fails++;
            end
            if (m_axis_tdata[36:32] != want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count,
                       m_axis_tdata[36:32]);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result();
            rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        m_axis_tready <= (rx_wait == 0);
    end

    initial begin
        int n;
        int rep;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        fails   = 0;
        cycles  = 0;
        rx_wait = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        pair_count = 0;
        allow_dup  = 1'b1;

        // The directed table. It runs with duplicates allowed after reset.
        // It then works on an empty table, a table filled to the last
        // place, and a table that has been partly emptied.
        add_row(op_typed(MODE_READ, 16'h1234, 16'h5678, 4'd0,
                         ST_RANGE, 16'h0, 16'h0, 5'd0));
        add_row(op_typed(MODE_REMOVE, 16'h0, 16'h0, 4'd3,
                         ST_RANGE, 16'h0, 16'h0, 5'd0));
        add_row(op_typed(MODE_IGNORED, 16'hFFFF, 16'hFFFF, 4'd15,
                         ST_OK, 16'h0, 16'h0, 5'd0));
        add_row(op_typed(MODE_ADD, 16'h0000, 16'h0000, 4'd0,
                         ST_OK, 16'h0, 16'h0, 5'd1));
        add_row(op_typed(MODE_ADD, 16'hFFFF, 16'hFFFF, 4'd15,
                         ST_OK, 16'h0, 16'h0, 5'd2));
        add_row(op_typed(MODE_READ, 16'h0, 16'h0, 4'd1,
                         ST_OK, 16'hFFFF, 16'hFFFF, 5'd2));
        // An identical pair goes in while duplicates are allowed.
        add_row(op_typed(MODE_ADD, 16'h0000, 16'h0000, 4'd0,
                         ST_OK, 16'h0, 16'h0, 5'd3));
        add_row(cfg_row(1'b0));
        add_row(op_typed(MODE_ADD, 16'hFFFF, 16'hFFFF, 4'd0,
                         ST_DUP, 16'h0, 16'h0, 5'd3));
        // A pair that shares only its key with a stored pair is accepted.
        add_row(op_model(MODE_ADD, 16'hFFFF, 16'h0000, 4'd0, 8'd1));
        add_row(op_model(MODE_ADD, 16'h1000, 16'h2000, 4'd0, 8'd12));
        add_row(op_typed(MODE_ADD, 16'h5555, 16'hAAAA, 4'd0,
                         ST_FULL, 16'h0, 16'h0, 5'd16));
        // When the table is full, the duplicate check still wins.
        add_row(op_typed(MODE_ADD, 16'h0000, 16'h0000, 4'd0,
                         ST_DUP, 16'h0, 16'h0, 5'd16));
        add_row(op_model(MODE_READ, 16'h0, 16'h0, 4'd15, 8'd1));
        add_row(op_model(MODE_REMOVE, 16'h0, 16'h0, 4'd15, 8'd1));
        add_row(op_model(MODE_REMOVE, 16'h0, 16'h0, 4'd0, 8'd1));
        add_row(op_typed(MODE_READ, 16'h0, 16'h0, 4'd14,
                         ST_RANGE, 16'h0, 16'h0, 5'd14));
        add_row(op_typed(MODE_IGNORED, 16'hA5A5, 16'h5A5A, 4'd10,
                         ST_OK, 16'h0, 16'h0, 5'd14));
        add_row(cfg_row(1'b1));
        add_row(op_model(MODE_ADD, 16'h0000, 16'h0000, 4'd0, 8'd1));
        add_row(op_model(MODE_REMOVE, 16'h0, 16'h0, 4'd7, 8'd1));
        add_row(op_model(MODE_READ, 16'h0, 16'h0, 4'd13, 8'd1));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[row_i]) begin
            if (directed_ops[row_i].is_cfg) begin
                write_allow(directed_ops[row_i].cfg_val);
            end else begin
                for (rep = 0; rep < int'(directed_ops[row_i].reps); rep++) begin
                    put_op(directed_ops[row_i].mode, directed_ops[row_i].key + 16'(rep),
                           directed_ops[row_i].value + 16'(rep), directed_ops[row_i].index,
                           directed_ops[row_i].typed, directed_ops[row_i].want);
                end
            end
        end

        // The random phases switch the duplicate check on and off, and each
        // switch waits for the block to go idle.
        for (n = 0; n < RANDOM_PHASES; n++) begin
            write_allow(n % 2 == 0 ? 1'b0 : 1'b1);
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d adds, %0d removes, %0d reads and %0d ignored items;",
                 n_add, n_remove, n_read, n_ignored);
        $display("%0d duplicates, %0d full-table adds, %0d bad indexes; %0d results checked.",
                 n_dup, n_full, n_range, n_checked);
        if (fails == 0) begin
            $display("[pair_table_insert_remove_core] OK");
        end else begin
            $display("[pair_table_insert_remove_core] ERROR");
        end
        $finish;
    end

endmodule
